[design/ama_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ama_pkg
// Shared constants, widths and the arctangent table for the attitude block.
// ----------------------------------------------------------------------------
package ama_pkg;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int TABLE_LEN        = 24;
  localparam int HALF_TURN        = 18000;
  localparam int FULL_TURN        = 36000;
  localparam int ANG_W            = 24;   // centidegrees * 256, signed
  localparam int DECL_RESET       = -494;
  localparam int CFG_AW           = 1;
  localparam logic [CFG_AW-1:0] REG_DECL = 1'b0;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0: v = 24'sd1152000;  1: v = 24'sd680065;  2: v = 24'sd359328;
      3: v = 24'sd182400;   4: v = 24'sd91554;   5: v = 24'sd45822;
      6: v = 24'sd22916;    7: v = 24'sd11459;   8: v = 24'sd5730;
      9: v = 24'sd2865;     10: v = 24'sd1432;   11: v = 24'sd716;
      12: v = 24'sd358;     13: v = 24'sd179;    14: v = 24'sd90;
      15: v = 24'sd45;      16: v = 24'sd22;     17: v = 24'sd11;
      18: v = 24'sd6;       19: v = 24'sd3;      20: v = 24'sd1;
      21: v = 24'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

[design/ama_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ama_cell
// One registered CORDIC vectoring micro-rotation; passes side data along.
// ----------------------------------------------------------------------------
module ama_cell #(
  parameter int STEP  = 0,
  parameter int VW    = 40,
  parameter int SIDEW = 8
) (
  input  wire                                clk,
  input  wire                                en,
  input  wire logic signed [VW-1:0]          x_in,
  input  wire logic signed [VW-1:0]          y_in,
  input  wire logic signed [ama_pkg::ANG_W-1:0] z_in,
  input  wire logic [SIDEW-1:0]              side_in,
  output logic signed [VW-1:0]               x_out,
  output logic signed [VW-1:0]               y_out,
  output logic signed [ama_pkg::ANG_W-1:0]   z_out,
  output logic [SIDEW-1:0]                   side_out
);
  import ama_pkg::*;
  localparam logic signed [ANG_W-1:0] ATAN = atan_entry(STEP);
  logic signed [VW-1:0] x_nxt, y_nxt;
  logic signed [ANG_W-1:0] z_nxt;

  always_comb begin
    if (!y_in[VW-1]) begin
      x_nxt = x_in + (y_in >>> STEP);
      y_nxt = y_in - (x_in >>> STEP);
      z_nxt = z_in + ATAN;
    end else begin
      x_nxt = x_in - (y_in >>> STEP);
      y_nxt = y_in + (x_in >>> STEP);
      z_nxt = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out    <= x_nxt;
      y_out    <= y_nxt;
      z_out    <= z_nxt;
      side_out <= side_in;
    end
  end
endmodule
`default_nettype wire

[design/ama_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ama_sqrt_cell
// One registered step of the restoring integer square root (one result bit).
// ----------------------------------------------------------------------------
module ama_sqrt_cell #(
  parameter int STEP  = 0,
  parameter int NW    = 50,
  parameter int SIDEW = 8
) (
  input  wire              clk,
  input  wire              en,
  input  wire [NW-1:0]     n_in,
  input  wire [NW-1:0]     res_in,
  input  wire [SIDEW-1:0]  side_in,
  output logic [NW-1:0]    n_out,
  output logic [NW-1:0]    res_out,
  output logic [SIDEW-1:0] side_out
);
  localparam int BITPOS = NW - 2 - 2 * STEP;
  localparam logic [NW-1:0] BIT = {{(NW-1){1'b0}}, 1'b1} << BITPOS;
  logic [NW-1:0] n_nxt, res_nxt, trial;

  always_comb begin
    trial = res_in + BIT;
    if (n_in >= trial) begin
      n_nxt   = n_in - trial;
      res_nxt = (res_in >> 1) + BIT;
    end else begin
      n_nxt   = n_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out    <= n_nxt;
      res_out  <= res_nxt;
      side_out <= side_in;
    end
  end
endmodule
`default_nettype wire

[design/accel_mag_attitude.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_mag_attitude
// Roll, pitch and tilt-free heading from accelerometer and magnetometer samples.
// ----------------------------------------------------------------------------
//  channel | direction | contents
//  in_     | slave     | accel_x, accel_y, accel_z, mag_x, mag_y
//  out_    | master    | roll_angle, pitch_angle, heading_angle
//  cfg_    | APB       | declination_centideg at address 0
// One sample per cycle unless out_tready stalls; each sample passes the
// SAMPLE_BITS+9 square root cells, the prerotation register, the CORDIC
// cells and the output register. The whole pipe advances when the output
// register is empty or being taken; a stall on out_tready freezes every
// stage. Reset clears valid bits and loads the declination with -494.
module accel_mag_attitude #(
  parameter int CORDIC_STEPS = ama_pkg::CORDIC_STEPS_DEF,
  parameter int SAMPLE_BITS  = ama_pkg::SAMPLE_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // accel_x, accel_y, accel_z, mag_x, mag_y, each SAMPLE_BITS, zero padded
  input  wire [((5*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // roll_angle[15:0], pitch_angle[30:16], heading_angle[46:31], pad
  output logic [47:0] out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire [ama_pkg::CFG_AW+1:0] cfg_paddr,
  input  wire [31:0]  cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ama_pkg::*;
  localparam int SB   = SAMPLE_BITS;
  localparam int NS   = CORDIC_STEPS;
  localparam int NW   = 2 * SB + 18;           // (ay^2+az^2)<<16, even
  localparam int RW   = NW / 2 + 1;
  localparam int VW   = SB + 8 + NS + 4;       // CORDIC vector width
  localparam int SQS  = NW / 2;                // sqrt cells
  localparam int SIDEW = 4 * SB;               // ax, ay, az, mx; the sqrt side adds my
  localparam logic signed [ANG_W-1:0] HT256 = ANG_W'(HALF_TURN * 256);

  // ---------------- config ----------------
  logic signed [15:0] decl_r;
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) decl_r <= 16'(DECL_RESET);
    else if (cfg_psel && cfg_penable && cfg_pwrite &&
             cfg_paddr[CFG_AW+1:2] == REG_DECL && cfg_paddr[1:0] == 2'b00)
      decl_r <= cfg_pwdata[15:0];
  end
  assign cfg_prdata = (cfg_paddr[CFG_AW+1:2] == REG_DECL) ?
                      {{16{decl_r[15]}}, decl_r} : 32'd0;

  // ---------------- flow ----------------
  localparam int DEPTH = SQS + 1 + NS;
  logic [DEPTH-1:0] vld_r;
  logic adv;
  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
  end

  logic signed [SB-1:0] ax, ay, az, mx, my;
  assign ax = in_tdata[SB-1:0];
  assign ay = in_tdata[2*SB-1:SB];
  assign az = in_tdata[3*SB-1:2*SB];
  assign mx = in_tdata[4*SB-1:3*SB];
  assign my = in_tdata[5*SB-1:4*SB];

  // ---------------- square-root chain ----------------
  logic [NW-1:0] sq_n [SQS+1];
  logic [NW-1:0] sq_r [SQS+1];
  logic [SIDEW+SB-1:0] sq_s [SQS+1];
  logic signed [2*SB-1:0] ay2, az2;
  assign ay2 = ay * ay;
  assign az2 = az * az;
  assign sq_n[0] = ({{(NW-2*SB){1'b0}}, ay2[2*SB-1:0]} +
                    {{(NW-2*SB){1'b0}}, az2[2*SB-1:0]}) << 16;
  assign sq_r[0] = '0;
  assign sq_s[0] = {my, mx, az, ay, ax};

  for (genvar g = 0; g < SQS; g++) begin : g_sq
    ama_sqrt_cell #(.STEP(g), .NW(NW), .SIDEW(SIDEW+SB)) u_sq (
      .clk(clk), .en(adv), .n_in(sq_n[g]), .res_in(sq_r[g]), .side_in(sq_s[g]),
      .n_out(sq_n[g+1]), .res_out(sq_r[g+1]), .side_out(sq_s[g+1]));
  end

  // ---------------- prerotation stage ----------------
  logic signed [SB-1:0] pax, pay, paz, pmx, pmy;
  assign {pmy, pmx, paz, pay, pax} = sq_s[SQS];

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ANG_W-1:0] z;
  } vec_t;

  function automatic vec_t prerot(input logic signed [VW-1:0] y,
                                  input logic signed [VW-1:0] x);
    vec_t v;
    v.x = x; v.y = y; v.z = '0;
    if (x < 0) begin
      v.z = (y >= 0) ? HT256 : -HT256;
      v.x = -x; v.y = -y;
    end
    return v;
  endfunction

  typedef struct packed {
    logic roll_zero;
    logic pitch_zero;
    logic head_zero;
    logic my_zero;
    logic mx_pos;
  } flags_t;

  vec_t v0 [3];
  flags_t f0;
  logic signed [VW-1:0] ry, rx, py, px, hy, hx;
  assign ry = VW'(pay) <<< 8;
  assign rx = VW'(paz) <<< 8;
  assign py = -(VW'(pax) <<< 8);
  assign px = VW'(sq_r[SQS][RW-1:0]);
  assign hy = -(VW'(pmx) <<< 8);
  assign hx = VW'(pmy) <<< 8;
  always_comb begin
    v0[0] = prerot(ry, rx);
    v0[1] = prerot(py, px);
    v0[2] = prerot(hy, hx);
    f0.roll_zero  = (ry == 0) && (rx == 0);
    f0.pitch_zero = (py == 0) && (px == 0);
    f0.head_zero  = (hy == 0) && (hx == 0);
    f0.my_zero    = (pmy == 0);
    f0.mx_pos     = !pmx[SB-1] && (pmx != 0);
  end

  vec_t v0_r [3];
  flags_t f0_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      v0_r <= v0;
      f0_r <= f0;
    end
  end

  vec_t c_v [3][NS+1];
  flags_t c_f [3][NS+1];

  for (genvar k = 0; k < 3; k++) begin : g_ch
    assign c_v[k][0] = v0_r[k];
    assign c_f[k][0] = f0_r;
    for (genvar g = 0; g < NS; g++) begin : g_c
      ama_cell #(.STEP(g), .VW(VW), .SIDEW($bits(flags_t))) u_c (
        .clk(clk), .en(adv),
        .x_in(c_v[k][g].x), .y_in(c_v[k][g].y), .z_in(c_v[k][g].z),
        .side_in(c_f[k][g]),
        .x_out(c_v[k][g+1].x), .y_out(c_v[k][g+1].y), .z_out(c_v[k][g+1].z),
        .side_out(c_f[k][g+1]));
    end
  end

  // ---------------- finish ----------------
  function automatic logic signed [ANG_W-9:0] rnd(input logic signed [ANG_W-1:0] z);
    logic signed [ANG_W-1:0] t;
    t = z + ANG_W'(128);
    return t[ANG_W-1:8];
  endfunction

  flags_t ff;
  logic signed [ANG_W-9:0] ra, pa, ha;
  logic signed [17:0] hd;
  logic [15:0] roll_nxt, head_nxt;
  logic [14:0] pitch_nxt;
  always_comb begin
    ff = c_f[0][NS];
    ra = ff.roll_zero  ? '0 : rnd(c_v[0][NS].z);
    pa = ff.pitch_zero ? '0 : rnd(c_v[1][NS].z);
    ha = ff.head_zero  ? '0 : rnd(c_v[2][NS].z);
    if (ra > 18000) ra = 16'sd18000;
    else if (ra < -18000) ra = -16'sd18000;
    if (pa > 9000) pa = 16'sd9000;
    else if (pa < -9000) pa = -16'sd9000;
    if (ff.my_zero) ha = ff.mx_pos ? 16'sd18000 : 16'sd0;
    // head in -18000..18000, decl in -32768..32767: at most two wraps each way
    hd = 18'(ha) - 18'(decl_r);
    if (hd < 0) hd = hd + 18'sd36000;
    if (hd < 0) hd = hd + 18'sd36000;
    if (hd >= 36000) hd = hd - 18'sd36000;
    if (hd >= 36000) hd = hd - 18'sd36000;
    roll_nxt  = ra[15:0];
    pitch_nxt = pa[14:0];
    head_nxt  = hd[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (adv) out_tvalid <= vld_r[DEPTH-1];
  end
  always_ff @(posedge clk) begin
    if (adv) out_tdata <= {1'b0, head_nxt, pitch_nxt, roll_nxt};
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[46:31] < 16'd36000)
    else $error("heading out of range");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("pipe advance mismatch");
endmodule
`default_nettype wire
